### rtl/asp_pkg.sv
package asp_pkg;

  // Sizes of the item fields
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 5;

  // Defaults handed to the top level
  localparam int unsigned NUM_SLOTS_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [TIME_W-1:0] OLDEST_RESET = 16'd2560;

  // Stream packing
  localparam int unsigned IN_DATA_W  = 48;  // delta, id, falloff
  localparam int unsigned OUT_DATA_W = 40;  // 38 used bits, padded to bytes

  // APB
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_OLDEST = 1'b0;  // register index, taken from paddr[2]

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } asp_kind_e;

  typedef logic [SLOT_W-1:0] asp_slot_t;

  typedef struct packed {
    asp_kind_e         kind;
    logic [TIME_W-1:0] delta_time;
    logic [ID_W-1:0]   entity_id;
    logic [TIME_W-1:0] time_falloff;
  } asp_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] max_falloff;
    asp_slot_t         slot_index;
    logic              added;
    logic [TIME_W-1:0] last_age;
  } asp_result_t;

endpackage

### rtl/asp_front.sv
module asp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [asp_pkg::KIND_W-1:0]      in_kind_i,
  input  logic [asp_pkg::IN_DATA_W-1:0]   in_data_i,
  output logic                            push_o,
  input  logic                            push_ready_i,
  output asp_pkg::asp_item_t              item_o
);

  logic               vld_q, vld_d;
  asp_pkg::asp_item_t item_q, item_d;
  asp_pkg::asp_kind_e kind;

  // every 2-bit code is a member of the kind enum
  assign kind = asp_pkg::asp_kind_e'(in_kind_i);

  assign in_ready_o = !vld_q || push_ready_i;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (push_ready_i) begin
      vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      vld_d               = 1'b1;
      item_d.kind         = kind;
      item_d.delta_time   = in_data_i[15:0];
      item_d.entity_id    = in_data_i[31:16];
      item_d.time_falloff = in_data_i[47:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      item_q <= '0;
    end else begin
      vld_q  <= vld_d;
      item_q <= item_d;
    end
  end

  assign push_o = vld_q;
  assign item_o = item_q;

endmodule

### rtl/asp_queue.sv
module asp_queue #(
  parameter int unsigned DEPTH = asp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               push_ready_o,
  input  asp_pkg::asp_item_t item_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output asp_pkg::asp_item_t item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  asp_pkg::asp_item_t ent_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign item_o       = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/asp_back.sv
module asp_back #(
  parameter int unsigned NUM_SLOTS = asp_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [asp_pkg::TIME_W-1:0]        oldest_i,
  input  logic                              pop_valid_i,
  output logic                              pop_o,
  input  asp_pkg::asp_item_t                item_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output asp_pkg::asp_result_t              res_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TW = asp_pkg::TIME_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Slot store: one write and one registered read a cycle
  logic [TW-1:0]           age_mem [NUM_SLOTS];
  logic [asp_pkg::ID_W-1:0] own_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    vld_q;
  logic [TW-1:0]           age_rd_q;
  logic [asp_pkg::ID_W-1:0] own_rd_q;
  logic                    rd_vld_q;

  state_e                  state_q;
  asp_pkg::asp_item_t      cur_q;
  logic [CW-1:0]           rd_cnt_q;
  logic                    p_vld_q;
  logic [IW-1:0]           p_idx_q;
  logic                    found_q, have_q;
  logic [IW-1:0]           pick_q;
  logic [TW-1:0]           best_q, res_q, peak_q;
  logic                    out_vld_q;
  asp_pkg::asp_result_t    out_q;

  logic                    scan_rd;
  logic [IW-1:0]           rd_addr;
  logic [TW-1:0]           age_eff;
  logic [asp_pkg::ID_W-1:0] own_eff;
  logic [TW:0]             sum;
  logic [TW-1:0]           tick_age;
  logic                    out_free, add_hit, out_set;
  logic [TW-1:0]           peak_nxt;
  logic                    we;
  logic [IW-1:0]           wa;
  logic [TW-1:0]           wage;
  logic [asp_pkg::ID_W-1:0] wown;

  assign scan_rd  = (state_q == ST_SCAN) && (rd_cnt_q < CW'(NUM_SLOTS));
  assign rd_addr  = rd_cnt_q[IW-1:0];
  assign age_eff  = rd_vld_q ? age_rd_q : asp_pkg::OLDEST_RESET;
  assign own_eff  = rd_vld_q ? own_rd_q : '0;
  assign sum      = {1'b0, age_eff} + {1'b0, cur_q.delta_time};
  assign tick_age = (sum > {1'b0, oldest_i}) ? oldest_i : sum[TW-1:0];
  assign out_free = !out_vld_q || res_ready_i;
  assign out_set  = (state_q == ST_DONE) && out_free;
  assign add_hit  = (cur_q.kind == asp_pkg::KIND_ADD) && have_q;
  assign peak_nxt = (add_hit && (cur_q.time_falloff > peak_q)) ? cur_q.time_falloff : peak_q;
  assign pop_o    = (state_q == ST_IDLE) && pop_valid_i;

  always_comb begin
    we   = 1'b0;
    wa   = p_idx_q;
    wage = tick_age;
    wown = own_eff;
    if ((state_q == ST_SCAN) && p_vld_q && (cur_q.kind == asp_pkg::KIND_TICK)) begin
      we = 1'b1;
    end else if ((state_q == ST_DONE) && out_free && add_hit) begin
      we   = 1'b1;
      wa   = pick_q;
      wage = '0;
      wown = cur_q.entity_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      age_mem[wa] <= wage;
      own_mem[wa] <= wown;
    end
    age_rd_q <= age_mem[rd_addr];
    own_rd_q <= own_mem[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
  end

  // Valid bits: an unwritten slot reads as free with owner zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      rd_cnt_q  <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      found_q   <= 1'b0;
      have_q    <= 1'b0;
      pick_q    <= '0;
      best_q    <= '0;
      res_q     <= '0;
      peak_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      // a new result replaces a taken one in the same cycle
      out_vld_q <= out_set || (out_vld_q && !res_ready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            cur_q    <= item_i;
            rd_cnt_q <= '0;
            p_vld_q  <= 1'b0;
            found_q  <= 1'b0;
            have_q   <= 1'b0;
            pick_q   <= '0;
            best_q   <= '0;
            res_q    <= oldest_i;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p_vld_q <= scan_rd;
          p_idx_q <= rd_addr;
          if (scan_rd) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (p_vld_q) begin
            if ((cur_q.kind == asp_pkg::KIND_ADD) && !found_q) begin
              if (age_eff == oldest_i) begin
                found_q <= 1'b1;
                have_q  <= 1'b1;
                pick_q  <= p_idx_q;
              end else if (age_eff > best_q) begin
                have_q  <= 1'b1;
                pick_q  <= p_idx_q;
                best_q  <= age_eff;
              end
            end
            if ((cur_q.kind == asp_pkg::KIND_QUERY) && (own_eff == cur_q.entity_id)
                && (age_eff < res_q)) begin
              res_q <= age_eff;
            end
          end
          if (!scan_rd && !p_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            peak_q            <= peak_nxt;
            out_q.last_age    <= (cur_q.kind == asp_pkg::KIND_QUERY) ? res_q : '0;
            out_q.added       <= add_hit;
            out_q.slot_index  <= add_hit ? asp_pkg::asp_slot_t'(pick_q) : '0;
            out_q.max_falloff <= peak_nxt;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

### rtl/aged_slot_pool_replacement_top.sv
// Aged slot pool with oldest-entry replacement.
// Items enter on the s_axis channel: tuser carries the kind (tick, add,
// query, or an unused code that only reports the falloff peak) and tdata
// the delta time, the entity id and the falloff time. Every item yields
// exactly one result on m_axis: last age for a query, added flag and slot
// index for an add, and the running falloff peak for all kinds.
// The oldest_time register sits at APB byte address 0; write it only while
// the block is idle. Reads return it in the low 16 bits.
// A front stage registers and decodes each item into a short queue; the
// back engine pops one item at a time and walks the slot store, one slot a
// cycle through its single read port.
// When m_axis stalls the finished result is held in the output register;
// the engine may scan the next item meanwhile and waits only to deliver it,
// and s_axis keeps accepting until queue and front register are full.
// Reset clears all control state at once: every slot reads as free with
// owner zero, the peak is zero and oldest_time returns to 2560.
module aged_slot_pool_replacement_top #(
  parameter int unsigned NUM_SLOTS   = asp_pkg::NUM_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = asp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [asp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // delta_time, entity_id, time_falloff
  input  logic [asp_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [asp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // last_age, added, slot_index, max_falloff
  // APB
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [asp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [asp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [asp_pkg::TIME_W-1:0] oldest_q;
  logic                       push, push_ready, pop_valid, pop;
  asp_pkg::asp_item_t         front_item, queue_item;
  asp_pkg::asp_result_t       res;

  // Config register; only register index 0 exists
  assign pready = 1'b1;
  assign prdata = (paddr[2] == asp_pkg::REG_OLDEST)
                  ? {{(asp_pkg::APB_DATA_W - asp_pkg::TIME_W){1'b0}}, oldest_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= asp_pkg::OLDEST_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == asp_pkg::REG_OLDEST)) begin
      oldest_q <= pwdata[asp_pkg::TIME_W-1:0];
    end
  end

  asp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  asp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (front_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .item_o       (queue_item)
  );

  asp_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .oldest_i    (oldest_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (queue_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

### rtl/asp_checker.sv
module asp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [asp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // no result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a dropped or non-add result reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[21:17] == 5'd0)
    else $error("slot index without add");

  // an add never reports an age
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("age reported on add");

endmodule

bind aged_slot_pool_replacement_top asp_checker u_asp_checker (.*);
